/* src/audio_channel_matrix_mixer_assert.svh */
// assertion macros for the channel matrix mixer
`ifndef AUDIO_CHANNEL_MATRIX_MIXER_ASSERT_SVH
`define AUDIO_CHANNEL_MATRIX_MIXER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, held off during reset
`define ACMM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, held off during reset
`define ACMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACMM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ACMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* src/acmm_pkg.sv */
// shared types and constants for the channel matrix mixer
package acmm_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 14;
  localparam int COUNT_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int ROW_W        = GAIN_BITS * MAX_CHANNELS;
  localparam int PROD_W       = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int ACC_W        = PROD_W + $clog2(MAX_CHANNELS);

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [COUNT_W-1:0]   COUNT_RESET = COUNT_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_COUNT   = 3'd0,
    REG_OUT_COUNT  = 3'd1,
    REG_GAIN_ROW_0 = 3'd2,
    REG_GAIN_ROW_1 = 3'd3,
    REG_GAIN_ROW_2 = 3'd4,
    REG_GAIN_ROW_3 = 3'd5,
    REG_MUTE       = 3'd6
  } cfg_reg_t;

  // result of one output lane before muting and lane masking
  typedef struct packed {
    sample_t value;
    logic    clip;
  } lane_res_t;

endpackage

/* src/acmm_if.sv */
// stream and configuration channels of the channel matrix mixer
interface acmm_in_if;
  import acmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

interface acmm_out_if;
  import acmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_0;
  sample_t out_1;
  sample_t out_2;
  sample_t out_3;
  logic    clipped;
  modport source (output valid, out_0, out_1, out_2, out_3, clipped, input ready);
  modport sink (input valid, out_0, out_1, out_2, out_3, clipped, output ready);
endinterface

interface acmm_cfg_if;
  import acmm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ROW_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/acmm_lane.sv */
// one output lane: products, sum, floor and saturate
module acmm_lane (
  input  acmm_pkg::sample_t   smp [acmm_pkg::MAX_CHANNELS],
  input  acmm_pkg::gain_t     gain [acmm_pkg::MAX_CHANNELS],
  input  logic [acmm_pkg::MAX_CHANNELS-1:0] in_act,
  output acmm_pkg::lane_res_t res
);
  import acmm_pkg::*;

  logic signed [PROD_W-1:0] prod [MAX_CHANNELS];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-GAIN_FRAC-1:0] floored;
  logic [ACC_W-GAIN_FRAC-SAMPLE_BITS:0] top_bits;

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      prod[i] = in_act[i] ? PROD_W'(smp[i] * $signed({1'b0, gain[i]})) : '0;
      acc = acc + ACC_W'(prod[i]);
    end
    // arithmetic shift drops the fraction, rounding toward minus infinity
    floored  = (ACC_W-GAIN_FRAC)'(acc >>> GAIN_FRAC);
    top_bits = floored[ACC_W-GAIN_FRAC-1:SAMPLE_BITS-1];
    res.clip = !((&top_bits) || !(|top_bits));
    if (res.clip) begin
      res.value = floored[ACC_W-GAIN_FRAC-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      res.value = floored[SAMPLE_BITS-1:0];
    end
  end

endmodule

/* src/audio_channel_matrix_mixer.sv */
// Channel matrix mixer: four Q1.15 inputs times a 4x4 matrix of unsigned Q2.14
// gains, summed, floored to Q1.15 and saturated per output, one frame per clock.
// A frame passes an input register and a result register; the 16 multipliers (one
// per gain), the sums, the floor and the saturation sit between them, so a result
// is offered on out_ch once the result register has loaded it. The whole pipeline
// advances together and holds when the result register is full and not taken,
// so throughput is one frame per cycle whenever out_ch.ready stays high.
// Configuration writes are always taken (cfg.ready is high) and act on frames
// loaded into the result register at later edges; a write to an index beyond the
// register list is ignored.
`include "audio_channel_matrix_mixer_assert.svh"

module audio_channel_matrix_mixer (
  input logic         clk,
  input logic         rst,
  acmm_in_if.sink     in_ch,
  acmm_out_if.source  out_ch,
  acmm_cfg_if.sink    cfg
);
  import acmm_pkg::*;

  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] out_count;
  logic [ROW_W-1:0]   gain_row [MAX_CHANNELS];
  logic               mute;

  logic      adv;
  logic      s1_valid;
  logic      o_valid;
  sample_t   s1_smp [MAX_CHANNELS];
  sample_t   out_word [MAX_CHANNELS];
  logic      clipped;

  logic [MAX_CHANNELS-1:0] in_act;
  gain_t     gcol [MAX_CHANNELS][MAX_CHANNELS];
  lane_res_t lane_res [MAX_CHANNELS];
  sample_t   out_word_next [MAX_CHANNELS];
  logic      clipped_next;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= COUNT_RESET;
      out_count <= COUNT_RESET;
      mute      <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        gain_row[i] <= ROW_W'(GAIN_ONE) << (GAIN_BITS * i);
      end
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_IN_COUNT:   in_count    <= cfg.data[COUNT_W-1:0];
        REG_OUT_COUNT:  out_count   <= cfg.data[COUNT_W-1:0];
        REG_GAIN_ROW_0: gain_row[0] <= cfg.data;
        REG_GAIN_ROW_1: gain_row[1] <= cfg.data;
        REG_GAIN_ROW_2: gain_row[2] <= cfg.data;
        REG_GAIN_ROW_3: gain_row[3] <= cfg.data;
        REG_MUTE:       mute        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the result register is free or being taken
  assign adv         = !o_valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
      o_valid  <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp[0] <= in_ch.sample_0;
      s1_smp[1] <= in_ch.sample_1;
      s1_smp[2] <= in_ch.sample_2;
      s1_smp[3] <= in_ch.sample_3;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      in_act[i] = COUNT_W'(i) < in_count;
      for (int j = 0; j < MAX_CHANNELS; j++) begin
        gcol[j][i] = gain_row[i][GAIN_BITS*j +: GAIN_BITS];
      end
    end
  end

  for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_lane
    acmm_lane u_lane (
      .smp    (s1_smp),
      .gain   (gcol[j]),
      .in_act (in_act),
      .res    (lane_res[j])
    );
  end

  // inactive or muted outputs read zero and never flag clipping
  always_comb begin
    clipped_next = 1'b0;
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      if (!mute && (COUNT_W'(j) < out_count)) begin
        out_word_next[j] = lane_res[j].value;
        clipped_next     = clipped_next | lane_res[j].clip;
      end else begin
        out_word_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= out_word_next;
      clipped  <= clipped_next;
    end
  end

  assign out_ch.valid   = o_valid;
  assign out_ch.out_0   = out_word[0];
  assign out_ch.out_1   = out_word[1];
  assign out_ch.out_2   = out_word[2];
  assign out_ch.out_3   = out_word[3];
  assign out_ch.clipped = clipped;

  `ACMM_ASSERT_NEXT(a_accept_fills, clk, rst, in_ch.valid && in_ch.ready, s1_valid, "accepted word lost at input stage")
  `ACMM_ASSERT_NEXT(a_mute_zero, clk, rst, adv && mute, out_word[0] == '0 && out_word[1] == '0 && out_word[2] == '0 && out_word[3] == '0 && !clipped, "muted result not zero")
  `ACMM_ASSERT_NEXT(a_inactive_zero, clk, rst, adv && (out_count < COUNT_W'(MAX_CHANNELS)), out_word[MAX_CHANNELS-1] == '0, "inactive output lane not zero")

endmodule
